// ===== design/hse_pkg.sv =====
package hse_pkg;

  localparam int CMD_W       = 2;
  localparam int PIXEL_W     = 8;
  localparam int PERCENT_W   = 7;
  localparam int DISCARD_W   = 24;
  localparam int N_W         = 24;
  localparam int SUM_W       = 32;
  localparam int SUMSQ_W     = 40;
  localparam int MEAN_W      = 16;
  localparam int VAR_W       = 23;
  localparam int LEVEL_W     = 8;
  localparam int TRIM_W      = 9;

  // Internal arithmetic widths.
  localparam int ACC_W       = 64;
  localparam int MUL_W       = 64;
  localparam int PROD_W      = 128;
  localparam int DVD_W       = 104;
  localparam int DVS_W       = 64;
  localparam int QB_W        = 5;
  localparam int MEAN_QBITS  = 16;
  localparam int VAR_QBITS   = 23;
  localparam int FULL_PERCENT = 100;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_code_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD,
    S_PREP,
    S_UP,
    S_DN,
    S_DRAIN,
    S_MEAN,
    S_MUL_A,
    S_MUL_B,
    S_VAR_GO,
    S_VAR,
    S_OUT
  } state_t;

  typedef struct packed {
    logic add_rd;
    logic add_wr;
    logic clr_wr;
    logic n_clear;
    logic addr_init_up;
    logic addr_init_dn;
    logic addr_step;
    logic scan_rd;
    logic rep_init;
    logic rep_prep;
    logic div_start;
    logic div_var;
    logic mean_latch;
    logic mul_start;
    logic mul_b;
    logic nss_latch;
    logic ssq_latch;
    logic var_latch;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pix_ok;
    logic addr_last;
    logic pipe_busy;
    logic mul_done;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/hse_if.sv =====
interface hse_in_if;
  logic                          valid;
  logic                          ready;
  logic [hse_pkg::CMD_W-1:0]     cmd;
  logic [hse_pkg::PIXEL_W-1:0]   pixel;
  logic [hse_pkg::PERCENT_W-1:0] percent;

  modport source (output valid, cmd, pixel, percent, input ready);
  modport sink   (input valid, cmd, pixel, percent, output ready);
endinterface

interface hse_out_if;
  logic                               valid;
  logic                               ready;
  logic [hse_pkg::N_W-1:0]            n_pixels;
  logic [hse_pkg::SUM_W-1:0]          pixel_sum;
  logic [hse_pkg::SUMSQ_W-1:0]        pixel_sum_sq;
  logic [hse_pkg::MEAN_W-1:0]         mean_q8;
  logic [hse_pkg::VAR_W-1:0]          variance_q8;
  logic [hse_pkg::LEVEL_W-1:0]        mode_level;
  logic [hse_pkg::LEVEL_W-1:0]        percentile_level;
  logic [hse_pkg::TRIM_W-1:0]         low_level;
  logic signed [hse_pkg::TRIM_W-1:0]  high_level;

  modport source (output valid, n_pixels, pixel_sum, pixel_sum_sq, mean_q8, variance_q8,
                  mode_level, percentile_level, low_level, high_level, input ready);
  modport sink   (input valid, n_pixels, pixel_sum, pixel_sum_sq, mean_q8, variance_q8,
                  mode_level, percentile_level, low_level, high_level, output ready);
endinterface

// ===== design/hse_mul.sv =====
module hse_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [hse_pkg::MUL_W-1:0]   a,
  input  logic [hse_pkg::MUL_W-1:0]   b,
  output logic                        done,
  output logic [hse_pkg::PROD_W-1:0]  prod
);

  logic                       busy;
  logic [2:0]                 step;
  logic [hse_pkg::MUL_W-1:0]  ar;
  logic [hse_pkg::MUL_W-1:0]  br;
  logic [63:0]                part;
  logic [1:0]                 psh;
  logic                       pv;
  logic [hse_pkg::PROD_W-1:0] acc;
  logic [31:0]                asel;
  logic [31:0]                bsel;
  logic [6:0]                 shamt;

  assign asel = step[1] ? ar[63:32] : ar[31:0];
  assign bsel = step[0] ? br[63:32] : br[31:0];

  always_comb begin
    unique case (psh)
      2'd0:    shamt = 7'd0;
      2'd3:    shamt = 7'd64;
      default: shamt = 7'd32;
    endcase
  end

  // One 32x32 partial product per cycle, added in on the following cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pv   <= 1'b0;
      done <= 1'b0;
      step <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ar   <= a;
        br   <= b;
        step <= 3'd0;
        busy <= 1'b1;
        acc  <= '0;
        pv   <= 1'b0;
      end else if (busy) begin
        if (step < 3'd4) begin
          part <= 64'(asel) * 64'(bsel);
          psh  <= step[1:0];
          pv   <= 1'b1;
        end else begin
          pv <= 1'b0;
        end
        if (pv) begin
          acc <= acc + (hse_pkg::PROD_W'(part) << shamt);
        end
        if (step == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 3'd1;
      end
    end
  end

  assign prod = acc;

endmodule

// ===== design/hse_div.sv =====
module hse_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [hse_pkg::DVD_W-1:0]  dvd_in,
  input  logic [hse_pkg::DVS_W-1:0]  dvs_in,
  input  logic [hse_pkg::QB_W-1:0]   qb_in,
  output logic                       done,
  output logic [hse_pkg::VAR_W-1:0]  quot
);

  logic                      busy;
  logic                      init;
  logic                      sat;
  logic [hse_pkg::DVD_W-1:0] dvd;
  logic [hse_pkg::DVS_W-1:0] dvs;
  logic [hse_pkg::QB_W-1:0]  qb;
  logic [hse_pkg::QB_W-1:0]  k;
  logic [hse_pkg::DVS_W-1:0] rem;
  logic [hse_pkg::VAR_W-1:0] q;
  logic [hse_pkg::DVS_W:0]   rem2;
  logic [hse_pkg::VAR_W:0]   qmask;

  assign rem2  = {rem, dvd[7'(k - 5'd1)]};
  assign qmask = (24'd1 << qb) - 24'd1;

  // A quotient that needs more than qb bits saturates; otherwise the high part
  // of the dividend is already below the divisor and qb restoring steps follow.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      init <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd  <= dvd_in;
        dvs  <= dvs_in;
        qb   <= qb_in;
        busy <= 1'b1;
        init <= 1'b1;
      end else if (busy) begin
        if (init) begin
          sat  <= dvd >= (hse_pkg::DVD_W'(dvs) << qb);
          rem  <= hse_pkg::DVS_W'(dvd >> qb);
          k    <= qb;
          q    <= '0;
          init <= 1'b0;
        end else if (k != '0) begin
          if (rem2 >= {1'b0, dvs}) begin
            rem <= hse_pkg::DVS_W'(rem2 - {1'b0, dvs});
            q   <= {q[hse_pkg::VAR_W-2:0], 1'b1};
          end else begin
            rem <= rem2[hse_pkg::DVS_W-1:0];
            q   <= {q[hse_pkg::VAR_W-2:0], 1'b0};
          end
          k <= k - 5'd1;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = sat ? qmask[hse_pkg::VAR_W-1:0] : q;

endmodule

// ===== design/hse_ctrl.sv =====
module hse_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [hse_pkg::CMD_W-1:0]  in_cmd,
  output logic                       in_ready,
  output hse_pkg::ctrl_cmd_t         cmd,
  input  hse_pkg::dp_status_t        st
);

  hse_pkg::state_t state;
  hse_pkg::state_t state_next;

  assign in_ready = (state == hse_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hse_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      hse_pkg::S_CLEAR: begin
        cmd.clr_wr    = 1'b1;
        cmd.addr_step = 1'b1;
        if (st.addr_last) state_next = hse_pkg::S_IDLE;
      end
      hse_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (hse_pkg::cmd_code_t'(in_cmd))
            hse_pkg::CMD_ADD: begin
              if (st.pix_ok) begin
                cmd.add_rd = 1'b1;
                state_next = hse_pkg::S_ADD;
              end
            end
            hse_pkg::CMD_REPORT: begin
              cmd.rep_init     = 1'b1;
              cmd.addr_init_up = 1'b1;
              state_next       = hse_pkg::S_PREP;
            end
            hse_pkg::CMD_CLEAR: begin
              cmd.n_clear      = 1'b1;
              cmd.addr_init_up = 1'b1;
              state_next       = hse_pkg::S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      hse_pkg::S_ADD: begin
        cmd.add_wr = 1'b1;
        state_next = hse_pkg::S_IDLE;
      end
      hse_pkg::S_PREP: begin
        cmd.rep_prep = 1'b1;
        state_next   = hse_pkg::S_UP;
      end
      hse_pkg::S_UP: begin
        cmd.scan_rd   = 1'b1;
        cmd.addr_step = 1'b1;
        if (st.addr_last) begin
          cmd.addr_init_dn = 1'b1;
          state_next       = hse_pkg::S_DN;
        end
      end
      hse_pkg::S_DN: begin
        cmd.scan_rd   = 1'b1;
        cmd.addr_step = 1'b1;
        if (st.addr_last) state_next = hse_pkg::S_DRAIN;
      end
      hse_pkg::S_DRAIN: begin
        if (!st.pipe_busy) begin
          cmd.div_start = 1'b1;
          state_next    = hse_pkg::S_MEAN;
        end
      end
      hse_pkg::S_MEAN: begin
        if (st.div_done) begin
          cmd.mean_latch = 1'b1;
          cmd.mul_start  = 1'b1;
          state_next     = hse_pkg::S_MUL_A;
        end
      end
      hse_pkg::S_MUL_A: begin
        if (st.mul_done) begin
          cmd.nss_latch = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_b     = 1'b1;
          state_next    = hse_pkg::S_MUL_B;
        end
      end
      hse_pkg::S_MUL_B: begin
        if (st.mul_done) begin
          cmd.ssq_latch = 1'b1;
          state_next    = hse_pkg::S_VAR_GO;
        end
      end
      hse_pkg::S_VAR_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_var   = 1'b1;
        state_next    = hse_pkg::S_VAR;
      end
      hse_pkg::S_VAR: begin
        if (st.div_done) begin
          cmd.var_latch = 1'b1;
          state_next    = hse_pkg::S_OUT;
        end
      end
      hse_pkg::S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = hse_pkg::S_IDLE;
        end
      end
      default: state_next = hse_pkg::S_IDLE;
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("result loaded while the output register is occupied");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == hse_pkg::S_IDLE) |-> !st.pipe_busy)
    else $error("scan pipeline active while idle");

endmodule

// ===== design/hse_dp.sv =====
module hse_dp #(
  parameter int BINS       = 256,
  parameter int COUNT_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  hse_pkg::ctrl_cmd_t             cmd,
  output hse_pkg::dp_status_t            st,
  input  logic [hse_pkg::PIXEL_W-1:0]    pixel,
  input  logic [hse_pkg::PERCENT_W-1:0]  percent,
  input  logic                           cfg_we,
  input  logic [hse_pkg::DISCARD_W-1:0]  cfg_data,
  hse_out_if.source                      result
);

  localparam int IDX_W     = $clog2(BINS);
  localparam int LVL_W     = IDX_W + 1;
  localparam int CUM_W     = COUNT_BITS + IDX_W;
  localparam int PS_W      = COUNT_BITS + IDX_W;
  localparam int PSS_W     = COUNT_BITS + 2 * IDX_W;
  localparam int CMP_W     = CUM_W + hse_pkg::PERCENT_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [IDX_W-1:0]      TOP     = IDX_W'(BINS - 1);

  // Histogram store and its read and write ports.
  logic [COUNT_BITS-1:0] mem [BINS];
  logic [COUNT_BITS-1:0] rd_data;
  logic                  mem_we;
  logic                  mem_re;
  logic [IDX_W-1:0]      mem_wa;
  logic [IDX_W-1:0]      mem_ra;
  logic [COUNT_BITS-1:0] mem_wd;

  logic [COUNT_BITS-1:0]         n;
  logic [COUNT_BITS-1:0]         nm1;
  logic [IDX_W-1:0]              add_addr;
  logic [IDX_W-1:0]              addr;
  logic                          addr_dn;
  logic [hse_pkg::DISCARD_W-1:0] discard;
  logic                          bin_full;

  assign bin_full = (rd_data == CNT_MAX);
  assign mem_we   = (cmd.add_wr && !bin_full) || cmd.clr_wr;
  assign mem_wa   = cmd.clr_wr ? addr : add_addr;
  assign mem_wd   = cmd.clr_wr ? '0 : rd_data + 1'b1;
  assign mem_re   = cmd.add_rd || cmd.scan_rd;
  assign mem_ra   = cmd.add_rd ? IDX_W'(pixel) : addr;
  assign nm1      = n - 1'b1;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n       <= '0;
      addr    <= '0;
      addr_dn <= 1'b0;
      discard <= '0;
    end else begin
      if (cfg_we) discard <= cfg_data;
      if (cmd.n_clear) begin
        n <= '0;
      end else if (cmd.add_wr && !bin_full && n != CNT_MAX) begin
        n <= n + 1'b1;
      end
      if (cmd.addr_init_up) begin
        addr    <= '0;
        addr_dn <= 1'b0;
      end else if (cmd.addr_init_dn) begin
        addr    <= TOP;
        addr_dn <= 1'b1;
      end else if (cmd.addr_step) begin
        addr <= addr_dn ? addr - 1'b1 : addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_rd) add_addr <= IDX_W'(pixel);
  end

  // Scan pipeline: read, then products, then accumulate.
  logic                 v1, v2, d1, d2;
  logic [IDX_W-1:0]     idx1, idx2;
  logic [2*IDX_W-1:0]   ii1;
  logic [COUNT_BITS-1:0] c2;
  logic [PS_W-1:0]      ps2;
  logic [PSS_W-1:0]     pss2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.scan_rd;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    d1   <= addr_dn;
    idx1 <= addr;
    ii1  <= {{IDX_W{1'b0}}, addr} * {{IDX_W{1'b0}}, addr};
    d2   <= d1;
    idx2 <= idx1;
    c2   <= rd_data;
    ps2  <= {{IDX_W{1'b0}}, rd_data} * {{COUNT_BITS{1'b0}}, idx1};
    pss2 <= {{(2*IDX_W){1'b0}}, rd_data} * {{COUNT_BITS{1'b0}}, ii1};
  end

  // Report accumulators.
  logic [hse_pkg::PERCENT_W-1:0] pct_r;
  logic [CMP_W-1:0]              pn;
  logic [hse_pkg::DVS_W-1:0]     dd;
  logic [hse_pkg::ACC_W-1:0]     s, ss;
  logic [CUM_W-1:0]              cum_up, cum_dn, cum_up_inc, cum_dn_inc;
  logic [COUNT_BITS-1:0]         best;
  logic [IDX_W-1:0]              mode, first_nz, last_nz, perc;
  logic                          fnz_found, pfound, lfound, hfound;
  logic [LVL_W-1:0]              low;
  logic signed [LVL_W-1:0]       high;
  logic [hse_pkg::ACC_W:0]       ss_sum;
  logic                          hit_pct;
  logic                          pct100;

  assign cum_up_inc = cum_up + CUM_W'(c2);
  assign cum_dn_inc = cum_dn + CUM_W'(c2);
  assign ss_sum     = {1'b0, ss} + (hse_pkg::ACC_W + 1)'(pss2);
  assign hit_pct    = (CMP_W'(cum_up_inc) * CMP_W'(hse_pkg::FULL_PERCENT)) > pn;
  assign pct100     = (pct_r == hse_pkg::PERCENT_W'(hse_pkg::FULL_PERCENT));

  always_ff @(posedge clk) begin
    if (cmd.rep_init) begin
      pct_r     <= (percent > hse_pkg::PERCENT_W'(hse_pkg::FULL_PERCENT))
                   ? hse_pkg::PERCENT_W'(hse_pkg::FULL_PERCENT) : percent;
      s         <= '0;
      ss        <= '0;
      cum_up    <= '0;
      cum_dn    <= '0;
      best      <= '0;
      mode      <= '0;
      first_nz  <= '0;
      last_nz   <= '0;
      perc      <= '0;
      fnz_found <= 1'b0;
      pfound    <= 1'b0;
      lfound    <= 1'b0;
      hfound    <= 1'b0;
      low       <= LVL_W'(BINS);
      high      <= '1;
    end else begin
      if (cmd.rep_prep) begin
        pn <= CMP_W'(pct_r) * CMP_W'(n);
        dd <= hse_pkg::DVS_W'(n) * hse_pkg::DVS_W'(nm1);
      end
      if (v2 && !d2) begin
        s      <= s + hse_pkg::ACC_W'(ps2);
        ss     <= ss_sum[hse_pkg::ACC_W] ? '1 : ss_sum[hse_pkg::ACC_W-1:0];
        cum_up <= cum_up_inc;
        if (c2 > best) begin
          best <= c2;
          mode <= idx2;
        end
        if (c2 != '0) begin
          last_nz <= idx2;
          if (!fnz_found) begin
            first_nz  <= idx2;
            fnz_found <= 1'b1;
          end
          if (!pfound && hit_pct) begin
            perc   <= idx2;
            pfound <= 1'b1;
          end
        end
        if (!lfound && 64'(cum_up_inc) >= 64'(discard)) begin
          low    <= LVL_W'({1'b0, idx2} + 1'b1);
          lfound <= 1'b1;
        end
      end
      if (v2 && d2) begin
        cum_dn <= cum_dn_inc;
        if (!hfound && 64'(cum_dn_inc) >= 64'(discard)) begin
          high   <= LVL_W'({1'b0, idx2} - 1'b1);
          hfound <= 1'b1;
        end
      end
    end
  end

  // Shared divider for mean and variance, and a multiplier shared by the two variance products.
  logic                        mul_done, div_done;
  logic [hse_pkg::PROD_W-1:0]  mul_prod, nss, ssq, num;
  logic [hse_pkg::VAR_W-1:0]   quot;
  logic [hse_pkg::MEAN_W-1:0]  mean;
  logic [hse_pkg::VAR_W-1:0]   var_q;
  logic [hse_pkg::DVD_W-1:0]   div_dvd;
  logic [hse_pkg::DVS_W-1:0]   div_dvs;
  logic [hse_pkg::QB_W-1:0]    div_qb;

  assign num     = nss - ssq;
  assign div_dvd = cmd.div_var ? {num[95:0], 8'd0} : {32'd0, s, 8'd0};
  assign div_dvs = cmd.div_var ? dd : hse_pkg::DVS_W'(n);
  assign div_qb  = cmd.div_var ? hse_pkg::QB_W'(hse_pkg::VAR_QBITS)
                               : hse_pkg::QB_W'(hse_pkg::MEAN_QBITS);

  hse_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (cmd.mul_b ? s : hse_pkg::MUL_W'(n)),
    .b     (cmd.mul_b ? s : ss),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  hse_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.div_start),
    .dvd_in (div_dvd),
    .dvs_in (div_dvs),
    .qb_in  (div_qb),
    .done   (div_done),
    .quot   (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.nss_latch)  nss  <= mul_prod;
    if (cmd.ssq_latch)  ssq  <= mul_prod;
    if (cmd.mean_latch) mean <= quot[hse_pkg::MEAN_W-1:0];
    if (cmd.var_latch) begin
      var_q <= (n < COUNT_BITS'(2) || nss < ssq) ? '0 : quot;
    end
  end

  // Output register.
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (n == '0) begin
        result.n_pixels         <= '0;
        result.pixel_sum        <= '0;
        result.pixel_sum_sq     <= '0;
        result.mean_q8          <= '0;
        result.variance_q8      <= '0;
        result.mode_level       <= '0;
        result.percentile_level <= '0;
        result.low_level        <= '0;
        result.high_level       <= hse_pkg::TRIM_W'(BINS - 1);
      end else begin
        result.n_pixels     <= ((64'(n) >> hse_pkg::N_W) != '0) ? '1 : hse_pkg::N_W'(n);
        result.pixel_sum    <= ((s >> hse_pkg::SUM_W) != '0) ? '1 : hse_pkg::SUM_W'(s);
        result.pixel_sum_sq <= ((ss >> hse_pkg::SUMSQ_W) != '0) ? '1 : hse_pkg::SUMSQ_W'(ss);
        result.mean_q8      <= mean;
        result.variance_q8  <= var_q;
        result.mode_level   <= hse_pkg::LEVEL_W'(mode);
        if (pct100) begin
          result.percentile_level <= hse_pkg::LEVEL_W'(last_nz);
        end else begin
          result.percentile_level <= pfound ? hse_pkg::LEVEL_W'(perc) : '0;
        end
        if (discard == '0) begin
          result.low_level  <= hse_pkg::TRIM_W'(first_nz);
          result.high_level <= hse_pkg::TRIM_W'(last_nz);
        end else begin
          result.low_level  <= hse_pkg::TRIM_W'(low);
          result.high_level <= hse_pkg::TRIM_W'(high);
        end
      end
    end
  end

  assign result.valid = out_valid;

  always_comb begin
    st.pix_ok    = {24'd0, pixel} < 32'(BINS);
    st.addr_last = addr_dn ? (addr == '0) : (addr == TOP);
    st.pipe_busy = v1 || v2;
    st.mul_done  = mul_done;
    st.div_done  = div_done;
    st.out_free  = !out_valid || result.ready;
  end

  a_port_conflict: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && cmd.scan_rd))
    else $error("histogram write during a scan read");

  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $past(v1))
    else $error("scan stage two valid without stage one");

endmodule

// ===== design/histogram_statistics_engine.sv =====
// Channel  Direction  Fields
// item     in         cmd, pixel, percent
// result   out        n_pixels, pixel_sum, pixel_sum_sq, mean_q8, variance_q8,
//                     mode_level, percentile_level, low_level, high_level
// cfg      in         cfg_we, cfg_data (discard_count)
//
// An add is a read of the bin from the histogram memory, then the write back.
// A report is an upward and a downward scan of the memory, one bin per cycle,
// then a 16-step division, two 4-product multiplies and a 23-step division.
// A clear, and reset, sweeps the memory one bin per cycle; no item is taken.
// A finished result waits in the output register while later adds and clears go on.
module histogram_statistics_engine #(
  parameter int BINS       = 256,
  parameter int COUNT_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  hse_in_if.sink                        item,
  hse_out_if.source                     result,
  input  logic                          cfg_we,
  input  logic [hse_pkg::DISCARD_W-1:0] cfg_data
);

  hse_pkg::ctrl_cmd_t  cmd;
  hse_pkg::dp_status_t st;
  logic                ready;

  hse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_cmd   (item.cmd),
    .in_ready (ready),
    .cmd      (cmd),
    .st       (st)
  );

  assign item.ready = ready;

  hse_dp #(
    .BINS       (BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .pixel    (item.pixel),
    .percent  (item.percent),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .result   (result)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam logic [hse_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int NUM_BINS = 256;
  localparam logic [hse_pkg::N_W-1:0] COUNT_MAX = '1;
  localparam int SETTLE_CYCLES = 2 * NUM_BINS + 120;

  typedef struct {
    logic [hse_pkg::N_W-1:0]            n_pixels;
    logic [hse_pkg::SUM_W-1:0]          pixel_sum;
    logic [hse_pkg::SUMSQ_W-1:0]        pixel_sum_sq;
    logic [hse_pkg::MEAN_W-1:0]         mean_q8;
    logic [hse_pkg::VAR_W-1:0]          variance_q8;
    logic [hse_pkg::LEVEL_W-1:0]        mode_level;
    logic [hse_pkg::LEVEL_W-1:0]        percentile_level;
    logic [hse_pkg::TRIM_W-1:0]         low_level;
    logic signed [hse_pkg::TRIM_W-1:0]  high_level;
  } stats_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [hse_pkg::DISCARD_W-1:0] cfg_data;

  hse_in_if  item ();
  hse_out_if result ();

  histogram_statistics_engine dut (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the histogram and its settings.
  logic [hse_pkg::N_W-1:0]       hist [NUM_BINS];
  logic [hse_pkg::N_W-1:0]       hist_total;
  logic [hse_pkg::DISCARD_W-1:0] trim_count;
  stats_t                        stats_due [$];

  bit errors;
  int burst_left;
  int hold_request;
  int stall_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic logic [hse_pkg::LEVEL_W-1:0] level_at_percent(longint unsigned n,
                                                                  int unsigned p);
    longint unsigned cum;
    int last;
    cum = 0;
    last = 0;
    if (p >= hse_pkg::FULL_PERCENT) begin
      for (int i = 0; i < NUM_BINS; i++)
        if (hist[i] != 0) last = i;
      return last[hse_pkg::LEVEL_W-1:0];
    end
    for (int i = 0; i < NUM_BINS; i++) begin
      cum += hist[i];
      if (hist[i] != 0 && 100 * cum > longint'(p) * n) return i[hse_pkg::LEVEL_W-1:0];
    end
    return '0;
  endfunction

  function automatic stats_t compute_stats(int unsigned pct);
    stats_t r;
    longint unsigned n, s, ss, best, acc, c;
    logic [127:0] lhs, rhs, quot, mean_w;
    int mode, idx, hi;
    n = hist_total;
    s = 0;
    ss = 0;
    best = 0;
    mode = 0;
    r = '{default: '0};
    if (n == 0) begin
      r.high_level = hse_pkg::TRIM_W'(NUM_BINS - 1);
      return r;
    end
    for (int i = 0; i < NUM_BINS; i++) begin
      c = hist[i];
      s += c * i;
      ss += c * i * i;
      if (c > best) begin
        best = c;
        mode = i;
      end
    end
    mean_w = (128'(s) << 8) / n;
    r.n_pixels = hse_pkg::N_W'(n);
    r.pixel_sum = (s > 64'hFFFF_FFFF) ? '1 : s[hse_pkg::SUM_W-1:0];
    r.pixel_sum_sq = (ss > 64'hFF_FFFF_FFFF) ? '1 : ss[hse_pkg::SUMSQ_W-1:0];
    r.mean_q8 = (mean_w > 128'hFFFF) ? '1 : mean_w[hse_pkg::MEAN_W-1:0];
    if (n >= 2) begin
      lhs = 128'(n) * 128'(ss);
      rhs = 128'(s) * 128'(s);
      if (lhs >= rhs) begin
        quot = ((lhs - rhs) << 8) / (128'(n) * 128'(n - 1));
        r.variance_q8 = (quot > 128'h7F_FFFF) ? '1 : quot[hse_pkg::VAR_W-1:0];
      end
    end
    r.mode_level = mode[hse_pkg::LEVEL_W-1:0];
    r.percentile_level = level_at_percent(n, (pct > hse_pkg::FULL_PERCENT)
                                             ? hse_pkg::FULL_PERCENT : pct);
    if (trim_count == 0) begin
      r.low_level = {1'b0, level_at_percent(n, 0)};
      r.high_level = {1'b0, level_at_percent(n, hse_pkg::FULL_PERCENT)};
    end else begin
      acc = 0;
      idx = 0;
      while (idx < NUM_BINS && acc < trim_count) begin
        acc += hist[idx];
        idx++;
      end
      r.low_level = idx[hse_pkg::TRIM_W-1:0];
      acc = 0;
      hi = NUM_BINS - 1;
      while (hi >= 0 && acc < trim_count) begin
        acc += hist[hi];
        hi--;
      end
      r.high_level = hi[hse_pkg::TRIM_W-1:0];
    end
    return r;
  endfunction

  task automatic apply_item(logic [hse_pkg::CMD_W-1:0] cmd, logic [hse_pkg::PIXEL_W-1:0] pix,
                            logic [hse_pkg::PERCENT_W-1:0] pct);
    if (cmd == hse_pkg::CMD_ADD) begin
      if (hist[pix] < COUNT_MAX) begin
        hist[pix]++;
        if (hist_total < COUNT_MAX) hist_total++;
      end
    end else if (cmd == hse_pkg::CMD_REPORT) begin
      stats_due = {stats_due, compute_stats(pct)};
    end else if (cmd == hse_pkg::CMD_CLEAR) begin
      foreach (hist[i]) hist[i] = '0;
      hist_total = '0;
    end
  endtask

  // Offers one item, with a random gap between bursts, and returns once it transfers.
  task automatic send_item(logic [hse_pkg::CMD_W-1:0] cmd, logic [hse_pkg::PIXEL_W-1:0] pix,
                           logic [hse_pkg::PERCENT_W-1:0] pct);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item.valid   <= 1'b1;
    item.cmd     <= cmd;
    item.pixel   <= pix;
    item.percent <= pct;
    do @(posedge clk); while (!item.ready);
    apply_item(cmd, pix, pct);
  endtask

  task automatic drain();
    item.valid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_trim(logic [hse_pkg::DISCARD_W-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    trim_count = value;
  endtask

  task automatic add_pixel(logic [hse_pkg::PIXEL_W-1:0] pix);
    send_item(hse_pkg::CMD_ADD, pix, hse_pkg::PERCENT_W'($urandom_range(0, 127)));
  endtask

  task automatic ask_report(logic [hse_pkg::PERCENT_W-1:0] pct);
    send_item(hse_pkg::CMD_REPORT, hse_pkg::PIXEL_W'($urandom), pct);
  endtask

  task automatic clear_hist();
    send_item(hse_pkg::CMD_CLEAR, hse_pkg::PIXEL_W'($urandom),
              hse_pkg::PERCENT_W'($urandom));
  endtask

  task automatic test_empty();
    ask_report(7'd50);
    ask_report(7'd127);
    send_item(CMD_UNUSED, 8'hFF, 7'd1);
    clear_hist();
    ask_report(7'd0);
  endtask

  task automatic test_extremes();
    add_pixel(8'd0);
    ask_report(7'd100);
    add_pixel(8'd255);
    add_pixel(8'hAA);
    add_pixel(8'h55);
    add_pixel(8'h55);
    add_pixel(8'hAA);
    ask_report(7'd0);
    ask_report(7'd50);
    ask_report(7'd99);
    ask_report(7'd100);
    ask_report(7'd101);
    ask_report(7'h7F);
    send_item(CMD_UNUSED, 8'd3, 7'd50);
    ask_report(7'd25);
  endtask

  // Trim setting extremes, including a trim larger than the whole histogram.
  task automatic test_trim();
    logic [hse_pkg::DISCARD_W-1:0] settings [5] = '{24'd1, 24'd3, 24'd6, 24'hFFFFFF, 24'd0};
    foreach (settings[k]) begin
      write_trim(settings[k]);
      ask_report(7'd50);
    end
  endtask

  // The receiver holds off while items keep coming, so the block must stall its input.
  task automatic test_backpressure();
    drain();
    hold_request = 2000;
    ask_report(7'd10);
    ask_report(7'd90);
    for (int i = 0; i < 40; i++) add_pixel(hse_pkg::PIXEL_W'($urandom));
    ask_report(7'd50);
    drain();
  endtask

  task automatic test_random();
    int adds_done;
    int run_len;
    int center;
    int spread;
    adds_done = 0;
    while (adds_done < 1700) begin
      case ($urandom_range(0, 9))
        0: clear_hist();
        1: send_item(CMD_UNUSED, hse_pkg::PIXEL_W'($urandom), hse_pkg::PERCENT_W'($urandom));
        2: begin
          case ($urandom_range(0, 3))
            0: write_trim('0);
            1: write_trim(24'hFFFFFF);
            default: write_trim(hse_pkg::DISCARD_W'($urandom_range(1, 40)));
          endcase
        end
        3: begin
          drain();
        end
        default: ;
      endcase
      run_len = $urandom_range(1, 60);
      center = $urandom_range(0, 255);
      spread = $urandom_range(0, 3) == 0 ? 255 : $urandom_range(0, 12);
      for (int i = 0; i < run_len; i++) begin
        if (spread == 255) add_pixel(hse_pkg::PIXEL_W'($urandom));
        else add_pixel(hse_pkg::PIXEL_W'((center + $urandom_range(0, spread)) % NUM_BINS));
      end
      adds_done += run_len;
      ask_report($urandom_range(0, 3) == 0 ? hse_pkg::PERCENT_W'($urandom)
                                            : hse_pkg::PERCENT_W'($urandom_range(0, 100)));
    end
  endtask

  // Receiver: a stall level picked now and then, plus a long hold-off on request.
  initial begin
    int cycles;
    result.ready = 1'b0;
    cycles = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        result.ready <= 1'b0;
        hold_request--;
      end else begin
        if (cycles % 150 == 0) begin
          case ($urandom_range(0, 3))
            0, 1: stall_pct = 0;
            2: stall_pct = 30;
            default: stall_pct = 80;
          endcase
        end
        result.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
      cycles++;
    end
  end

  always @(posedge clk) begin
    stats_t want;
    if (!rst && result.valid && result.ready) begin
      if (stats_due.size() == 0) begin
        $display("%t: result transfer with nothing expected", $realtime);
        errors = 1'b1;
      end else begin
        want = stats_due.pop_front();
        if (result.n_pixels !== want.n_pixels) begin
          $display("%t: n_pixels expected %0d actual %0d", $realtime,
                   want.n_pixels, result.n_pixels);
          errors = 1'b1;
        end
        if (result.pixel_sum !== want.pixel_sum) begin
          $display("%t: pixel_sum expected %0d actual %0d", $realtime,
                   want.pixel_sum, result.pixel_sum);
          errors = 1'b1;
        end
        if (result.pixel_sum_sq !== want.pixel_sum_sq) begin
          $display("%t: pixel_sum_sq expected %0d actual %0d", $realtime,
                   want.pixel_sum_sq, result.pixel_sum_sq);
          errors = 1'b1;
        end
        if (result.mean_q8 !== want.mean_q8) begin
          $display("%t: mean_q8 expected %0d actual %0d", $realtime,
                   want.mean_q8, result.mean_q8);
          errors = 1'b1;
        end
        if (result.variance_q8 !== want.variance_q8) begin
          $display("%t: variance_q8 expected %0d actual %0d", $realtime,
                   want.variance_q8, result.variance_q8);
          errors = 1'b1;
        end
        if (result.mode_level !== want.mode_level) begin
          $display("%t: mode_level expected %0d actual %0d", $realtime,
                   want.mode_level, result.mode_level);
          errors = 1'b1;
        end
        if (result.percentile_level !== want.percentile_level) begin
          $display("%t: percentile_level expected %0d actual %0d", $realtime,
                   want.percentile_level, result.percentile_level);
          errors = 1'b1;
        end
        if (result.low_level !== want.low_level) begin
          $display("%t: low_level expected %0d actual %0d", $realtime,
                   want.low_level, result.low_level);
          errors = 1'b1;
        end
        if (result.high_level !== want.high_level) begin
          $display("%t: high_level expected %0d actual %0d", $realtime,
                   want.high_level, result.high_level);
          errors = 1'b1;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    item.valid = 1'b0;
    item.cmd = hse_pkg::CMD_ADD;
    item.pixel = '0;
    item.percent = '0;
    errors = 1'b0;
    burst_left = 0;
    hold_request = 0;
    stall_pct = 0;
    foreach (hist[i]) hist[i] = '0;
    hist_total = '0;
    trim_count = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty();
    test_extremes();
    test_trim();
    test_backpressure();
    test_random();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!errors && stats_due.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      if (stats_due.size() != 0)
        $display("%t: %0d results never arrived", $realtime, stats_due.size());
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
